>>> hdl/assert_macros.svh
// Assertion macros; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/jse_pkg.sv
package jse_pkg;

  typedef enum logic [1:0] {
    CMD_OPEN   = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LT        = 8'h3c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;

  localparam int unsigned IdxW = 3;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [7:0] ch;
  } enc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'h0, nib};
    end else begin
      return 8'h57 + {4'h0, nib};
    end
  endfunction

endpackage

>>> hdl/jse_encoder.sv
module jse_encoder (
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 byte_i,
  input  logic [jse_pkg::IdxW-1:0]   idx_i,
  output jse_pkg::enc_t              enc_o
);
  import jse_pkg::*;

  logic             is_esc2;
  logic             is_esc6;
  logic [IdxW-1:0]  len;
  logic [7:0]       ch_sel;

  assign is_esc2 = (byte_i == CH_QUOTE) || (byte_i == CH_BACKSLASH);
  assign is_esc6 = (byte_i < CTRL_LIMIT) || (byte_i == CH_LT) ||
                   (byte_i == CH_GT) || (byte_i == CH_AMP);

  always_comb begin
    len    = '0;
    ch_sel = CH_QUOTE;
    unique case (cmd_i)
      CMD_OPEN, CMD_CLOSE: begin
        len    = IdxW'(1);
        ch_sel = CH_QUOTE;
      end
      CMD_DATA: begin
        if (is_esc2) begin
          len    = IdxW'(2);
          ch_sel = (idx_i == '0) ? CH_BACKSLASH : byte_i;
        end else if (is_esc6) begin
          len = IdxW'(6);
          unique case (idx_i)
            IdxW'(0): ch_sel = CH_BACKSLASH;
            IdxW'(1): ch_sel = CH_U;
            IdxW'(2): ch_sel = CH_ZERO;
            IdxW'(3): ch_sel = CH_ZERO;
            IdxW'(4): ch_sel = hex_digit(byte_i[7:4]);
            default:  ch_sel = hex_digit(byte_i[3:0]);
          endcase
        end else begin
          len    = IdxW'(1);
          ch_sel = byte_i;
        end
      end
      default: begin
        len    = '0;
        ch_sel = CH_QUOTE;
      end
    endcase
  end

  assign enc_o = '{emit: (len != '0),
                   last: ((len == '0) || (idx_i == len - IdxW'(1))),
                   ch:   ch_sel};

endmodule

>>> hdl/json_string_escaper_unit.sv
// Path: the accepted item is registered, the encoder runs on it, and each
// output beat is registered once more before it reaches the ports.
// Throughput: one beat per cycle; a data byte gives 1, 2 or 6 beats, open and
// close one quote each, unused command 3 none, and the next item is taken in the
// cycle the encoder forms the previous one's last beat. Receiver cannot stall.
// Reset: asynchronous, active low; clears item and result valid state.
module json_string_escaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_strobe_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import jse_pkg::*;
  `include "assert_macros.svh"

  logic             valid_q, valid_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [7:0]       byte_q, byte_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             strobe_q, strobe_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             accept;
  enc_t             enc;

  jse_encoder u_enc (
    .cmd_i  (cmd_q),
    .byte_i (byte_q),
    .idx_i  (idx_q),
    .enc_o  (enc)
  );

  assign busy   = valid_q && !enc.last;
  assign accept = start && !busy;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    byte_d  = byte_q;
    idx_d   = idx_q;
    priority if (accept) begin
      valid_d = 1'b1;
      cmd_d   = command_i;
      byte_d  = data_byte_i;
      idx_d   = '0;
    end else if (valid_q && enc.last) begin
      valid_d = 1'b0;
    end else if (valid_q) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  assign strobe_d = valid_q && enc.emit;
  assign obyte_d  = enc.ch;
  assign olast_d  = enc.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    byte_q  <= byte_d;
    idx_q   <= idx_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_strobe_o  = strobe_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = olast_q;

  `ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_strobe_o && !last_of_run_o, out_strobe_o)
  `ASSERT_NEXT(a_quote_single, clk_i, rst_ni, accept && (command_i != CMD_DATA) && (command_i != CMD_UNUSED), ##1 (out_strobe_o && last_of_run_o && (out_byte_o == CH_QUOTE)))
  `ASSERT_AT(a_busy_needs_item, clk_i, rst_ni, busy |-> (valid_q && (idx_q < IdxW'(5))))

endmodule

>>> verif/json_string_escaper_unit_test.sv
module json_string_escaper_unit_test;
  import jse_pkg::*;

  localparam int unsigned TotalItems = 110;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } text_cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } json_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] command = CMD_OPEN;
  logic [7:0] data_byte = 8'h00;
  logic       out_strobe;
  logic [7:0] out_byte;
  logic       last_of_run;

  text_cmd_t   command_backlog [$];
  json_beat_t  escaped_beats [$];
  int unsigned queued_real = 0;
  int unsigned idle_left = 0;
  int unsigned gap_roll;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  text_cmd_t   next_cmd;
  json_beat_t  want;

  json_string_escaper_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command),
    .data_byte_i  (data_byte),
    .out_strobe_o (out_strobe),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void escape_into_beats(input logic [1:0] cmd, input logic [7:0] b);
    string      hex_chars;
    logic [7:0] text [$];
    hex_chars = "0123456789abcdef";
    case (cmd)
      CMD_OPEN, CMD_CLOSE: begin
        text.push_back(CH_QUOTE);
      end
      CMD_DATA: begin
        if (b == CH_QUOTE || b == CH_BACKSLASH) begin
          text.push_back(CH_BACKSLASH);
          text.push_back(b);
        end else if (b < CTRL_LIMIT || b == CH_LT || b == CH_GT || b == CH_AMP) begin
          text.push_back(CH_BACKSLASH);
          text.push_back(CH_U);
          text.push_back(CH_ZERO);
          text.push_back(CH_ZERO);
          text.push_back(hex_chars[b[7:4]]);
          text.push_back(hex_chars[b[3:0]]);
        end else begin
          text.push_back(b);
        end
      end
      default: begin
      end
    endcase
    foreach (text[k]) begin
      escaped_beats.push_back('{ch: text[k], last: (k == text.size() - 1)});
    end
  endfunction

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] b);
    command_backlog.push_back('{command: cmd, data_byte: b});
    if (cmd != CMD_UNUSED) begin
      queued_real++;
    end
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] marks [5];
    marks = '{CH_QUOTE, CH_BACKSLASH, CH_LT, CH_GT, CH_AMP};
    case ($urandom_range(0, 3))
      0: return marks[$urandom_range(0, 4)];
      1: return 8'($urandom_range(0, 31));
      default: return 8'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        escape_into_beats(command, data_byte);
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (command_backlog.size() > 0) begin
          next_cmd = command_backlog.pop_front();
          command <= next_cmd.command;
          data_byte <= next_cmd.data_byte;
          start <= 1'b1;
          gap_roll = $urandom_range(0, 99);
          if (gap_roll < 60) begin
            idle_left = 0;
          end else if (gap_roll < 92) begin
            idle_left = $urandom_range(1, 3);
          end else begin
            idle_left = $urandom_range(6, 30);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe) begin
      if (escaped_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected beat: byte %h last %b", out_byte, last_of_run);
        end
      end else begin
        want = escaped_beats.pop_front();
        if (out_byte !== want.ch || last_of_run !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("beat mismatch: expected byte %h last %b, got byte %h last %b",
                     want.ch, want.last, out_byte, last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("json_string_escaper_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned target;

    // directed
    queue_item(CMD_OPEN, 8'ha5);
    queue_item(CMD_DATA, 8'h00);
    queue_item(CMD_DATA, 8'h1f);
    queue_item(CMD_DATA, 8'h0a);
    queue_item(CMD_DATA, 8'h20);
    queue_item(CMD_DATA, CH_QUOTE);
    queue_item(CMD_DATA, CH_BACKSLASH);
    queue_item(CMD_DATA, CH_LT);
    queue_item(CMD_DATA, CH_GT);
    queue_item(CMD_DATA, CH_AMP);
    queue_item(CMD_DATA, 8'h41);
    queue_item(CMD_DATA, 8'h7f);
    queue_item(CMD_DATA, 8'h80);
    queue_item(CMD_DATA, 8'hff);
    queue_item(CMD_UNUSED, 8'hff);
    queue_item(CMD_UNUSED, 8'h00);
    queue_item(CMD_DATA, 8'h3d);
    queue_item(CMD_CLOSE, CH_QUOTE);
    queue_item(CMD_OPEN, 8'hff);
    queue_item(CMD_CLOSE, 8'h00);

    // random: mostly whole strings, some stray and unused commands
    target = TotalItems;
    while (queued_real < target) begin
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        queue_item(CMD_OPEN, 8'($urandom));
        repeat ($urandom_range(0, 8)) queue_item(CMD_DATA, pick_text_byte());
        if ($urandom_range(0, 5) != 0) begin
          queue_item(CMD_CLOSE, 8'($urandom));
        end
      end else if (roll == 8) begin
        queue_item(CMD_UNUSED, 8'($urandom));
      end else begin
        queue_item(2'($urandom_range(CMD_DATA, CMD_CLOSE)), 8'($urandom));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_backlog.size() != 0 || start) @(posedge clk_i);
    while (escaped_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && escaped_beats.size() == 0) begin
      $display("json_string_escaper_unit regression: pass");
    end else begin
      $display("json_string_escaper_unit regression: fail");
    end
    $finish;
  end

endmodule
